[rtl/core/mbf_ieee_double_convert_defines.svh]
// assertion macros for the mbf to double converter
`ifndef MBF_IEEE_DOUBLE_CONVERT_DEFINES_SVH
`define MBF_IEEE_DOUBLE_CONVERT_DEFINES_SVH
// assert that a property holds, reset disables it
`define MBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assert during and after reset
`define MBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/mbf_pkg.sv]
// package of constants for the mbf to double converter
package mbf_pkg;
  localparam int unsigned DBL_BIAS = 1023;
  localparam int unsigned IN_W     = 96;
  localparam int unsigned OUT_W    = 104;
  typedef enum logic {
    CMD_MBF_TO_DBL = 1'b0,
    CMD_DBL_TO_MBF = 1'b1
  } cmd_t;
endpackage

[rtl/core/mbf_ieee_double_convert.sv]
// top level of the mbf to double converter
// Converts between the 4-byte MBF float and raw IEEE 754 double bits, one
// transfer per cycle unless m_tready back-pressure drops s_tready. tuser
// selects the direction (0 mbf to double, 1 double to mbf). A transfer passes
// an input register, short format logic, then an output register with a skid
// stage, so the input side takes one more transfer while a result waits and
// then drops s_tready. mbf to double is exact;
// double to mbf rounds half-up to 24 bits, flushes small values and zeros to
// mbf zero and flags too large, infinite and nan inputs with overflow_flag.
module mbf_ieee_double_convert #(
  parameter int unsigned EXP_BIAS = 129
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sign, mbf_exponent, mbf_fraction, double_bits
  input  logic [mbf_pkg::IN_W-1:0]  s_tdata,
  input  logic        s_tuser,           // command
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_double_bits, out_mbf_sign, out_mbf_exponent, out_mbf_fraction,
  // overflow_flag, zero fill
  output logic [mbf_pkg::OUT_W-1:0] m_tdata
);
  import mbf_pkg::*;

  // input stage
  logic        in_valid;
  logic [95:0] in_data;
  logic        in_cmd;
  // output register and skid
  logic        out_valid, skid_valid;
  logic [96:0] out_data, skid_data;
  logic        in_take;

  assign in_take  = in_valid && !skid_valid;
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_cmd  <= s_tuser;
    end
  end

  // field extraction
  logic        msign;
  logic [7:0]  mexpo;
  logic [22:0] mfrac;
  logic [63:0] dbits;
  assign msign = in_data[0];
  assign mexpo = in_data[8:1];
  assign mfrac = in_data[31:9];
  assign dbits = in_data[95:32];

  // mbf to double
  logic [63:0] cvt_dbl;
  logic [10:0] dexp_new;
  assign dexp_new = 11'(({3'd0, mexpo} + 11'(DBL_BIAS)) - 11'(EXP_BIAS));

  // double to mbf
  logic [10:0] dexp;
  logic [24:0] sig;
  logic [12:0] mexp;
  logic [22:0] rfrac;
  logic        cvt_sign, cvt_ovf;
  logic [7:0]  cvt_exp;
  logic [22:0] cvt_frac;

  always_comb begin
    cvt_dbl = 64'd0;
    if (mexpo != 8'd0) cvt_dbl = {msign, dexp_new, mfrac, 29'd0};
    dexp = dbits[62:52];
    sig  = {2'b01, dbits[51:29]} + {24'd0, dbits[28]};
    mexp = 13'({2'b00, dexp} + 13'(EXP_BIAS)) - 13'(DBL_BIAS);
    rfrac = sig[22:0];
    if (sig[24]) begin
      rfrac = sig[23:1];
      mexp  = mexp + 13'd1;
    end
    cvt_sign = 1'b0;
    cvt_exp  = 8'd0;
    cvt_frac = 23'd0;
    cvt_ovf  = 1'b0;
    if (dexp == 11'h7ff) begin
      cvt_ovf = 1'b1;
    end else if (dexp != 11'd0) begin
      if (!mexp[12] && mexp > 13'd255) begin
        cvt_ovf = 1'b1;
      end else if (!mexp[12] && mexp != 13'd0) begin
        cvt_sign = dbits[63];
        cvt_exp  = mexp[7:0];
        cvt_frac = rfrac;
      end
    end
  end

  logic [96:0] res;
  assign res = (in_cmd == CMD_DBL_TO_MBF) ?
               {cvt_ovf, cvt_frac, cvt_exp, cvt_sign, 64'd0} : {33'd0, cvt_dbl};

  logic out_free;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || in_valid;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        skid_valid <= 1'b1;
      end
    end
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (in_take) begin
      skid_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_data};
endmodule

[rtl/core/mbf_checker.sv]
// port checker for the mbf to double converter
`include "mbf_ieee_double_convert_defines.svh"
module mbf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);
  `MBF_ASSERT(stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall lost")
  `MBF_ASSERT(ovf_zero, m_tvalid && m_tdata[96] |-> m_tdata[95:64] == 32'd0, "overflow not zero")
  `MBF_ASSERT(one_dir, m_tvalid && m_tdata[63:0] != 64'd0 |-> m_tdata[96:64] == 33'd0, "both dirs")
  `MBF_ASSERT_ALWAYS(rst_idle, rst |=> !m_tvalid, "valid after reset")
endmodule

bind mbf_ieee_double_convert mbf_checker u_mbf_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
